[src/u8st_pkg.sv]
// ----------------------------------------------------------------------------
// u8st_pkg
// shared command and status types between the utf-8 sanitizer controller
// and its datapath
// ----------------------------------------------------------------------------
package u8st_pkg;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;        // take the request into the staging buffer
      logic shift;       // drop the head byte with no output
      logic push_byte;   // emit the head byte and drop it
      logic push_qmark;  // emit a replacement mark and drop the head byte
      logic push_end;    // emit the end result and clear the string state
      logic set_cap;     // cap reached: discard held bytes for the rest of the string
   } dp_cmd_type;

   // head-of-buffer decode and handshake status back to the controller
   typedef struct packed {
      logic       cnt_zero;  // staging buffer empty
      logic       wait_more; // head sequence incomplete, more bytes to come
      logic       bad;       // head sequence rejected
      logic       ctrl;      // head is a one-byte control to drop
      logic [2:0] len;       // length announced by the head lead byte
      logic       over_cap;  // next output would pass the byte cap
      logic       out_free;  // output register can take a result this cycle
      logic       last;      // current request closes the string
   } dp_status_type;

endpackage

[src/u8st_dp.sv]
// ----------------------------------------------------------------------------
// u8st_dp
// datapath: staging buffer, head sequence decode, cap counter, cap register
// and the registered result slot
// ----------------------------------------------------------------------------
module u8st_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  u8st_pkg::dp_cmd_type    cmd,
   output u8st_pkg::dp_status_type status,
   input  logic                    req_has_byte,
   input  logic [7:0]              req_data_byte,
   input  logic                    req_last,
   input  logic                    csr_valid,
   input  logic [15:0]             csr_max_out_bytes,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_is_end
);

   localparam logic [7:0]  QMARK      = 8'h3F;
   localparam logic [7:0]  DEL_CHAR   = 8'h7F;
   localparam logic [7:0]  SPACE_CHAR = 8'h20;
   localparam logic [15:0] CAP_RESET  = 16'd255;
   localparam logic [20:0] MIN_TWO    = 21'h00080;
   localparam logic [20:0] MIN_THREE  = 21'h00800;
   localparam logic [20:0] MIN_FOUR   = 21'h10000;
   localparam logic [20:0] SURR_LO    = 21'h0D800;
   localparam logic [20:0] SURR_HI    = 21'h0DFFF;
   localparam logic [20:0] CP_MAX     = 21'h10FFFF;

   logic [3:0][7:0] buf_ff, buf_in;
   logic [2:0]      cnt_ff, cnt_in;
   logic            last_ff, last_in;
   logic [15:0]     emitted_ff, emitted_in;
   logic            capped_ff, capped_in;
   logic [15:0]     max_ff, max_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      rsp_byte_ff, rsp_byte_in;
   logic            rsp_end_ff, rsp_end_in;

   logic [7:0]  c0;
   logic [2:0]  len;
   logic [2:0]  take;
   logic        bad_cont;
   logic        short;
   logic        lead_ok;
   logic        seq_ok;
   logic [20:0] cp;
   logic        range_bad;
   logic [16:0] need;
   logic        out_free;

   // ---- head decode ----
   always_comb begin
      c0 = buf_ff[0];
      priority if (c0[7] == 1'b0)        len = 3'd1;
      else if (c0[7:5] == 3'b110)        len = 3'd2;
      else if (c0[7:4] == 4'b1110)       len = 3'd3;
      else if (c0[7:3] == 5'b11110)      len = 3'd4;
      else                               len = 3'd0;
      take = (len < cnt_ff) ? len : cnt_ff;
      bad_cont = 1'b0;
      for (int k = 1; k < 4; k++) begin
         if ((3'(k) < take) && (buf_ff[k][7:6] != 2'b10)) bad_cont = 1'b1;
      end
      short   = cnt_ff < len;
      lead_ok = (len != 3'd0) && !bad_cont;
      unique case (len)
         3'd2:    cp = {10'd0, c0[4:0], buf_ff[1][5:0]};
         3'd3:    cp = {5'd0, c0[3:0], buf_ff[1][5:0], buf_ff[2][5:0]};
         3'd4:    cp = {c0[2:0], buf_ff[1][5:0], buf_ff[2][5:0], buf_ff[3][5:0]};
         default: cp = {13'd0, c0};
      endcase
      unique case (len)
         3'd2:    range_bad = cp < MIN_TWO;
         3'd3:    range_bad = (cp < MIN_THREE) || ((cp >= SURR_LO) && (cp <= SURR_HI));
         3'd4:    range_bad = (cp < MIN_FOUR) || (cp > CP_MAX);
         default: range_bad = 1'b0;
      endcase
      // incomplete at string end is rejected, incomplete otherwise waits
      seq_ok = lead_ok && !(short && last_ff) && !(!short && range_bad);
      need = seq_ok ? ({1'b0, emitted_ff} + {14'd0, len}) : ({1'b0, emitted_ff} + 17'd1);
      out_free = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      status.cnt_zero  = cnt_ff == 3'd0;
      status.wait_more = lead_ok && short && !last_ff;
      status.bad       = !seq_ok;
      status.ctrl      = seq_ok && (len == 3'd1) && ((c0 < SPACE_CHAR) || (c0 == DEL_CHAR));
      status.len       = len;
      status.over_cap  = need > {1'b0, max_ff};
      status.out_free  = out_free;
      status.last      = last_ff;
   end

   // ---- next state ----
   always_comb begin
      buf_in       = buf_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      emitted_in   = emitted_ff;
      capped_in    = capped_ff;
      max_in       = csr_valid ? csr_max_out_bytes : max_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_end_in   = rsp_end_ff;
      if (cmd.load) begin
         last_in = req_last;
         if (capped_ff) begin
            cnt_in = 3'd0;
         end else if (req_has_byte) begin
            buf_in[cnt_ff[1:0]] = req_data_byte;
            cnt_in = cnt_ff + 3'd1;
         end
      end
      if (cmd.shift || cmd.push_byte || cmd.push_qmark) begin
         buf_in = {8'h00, buf_ff[3:1]};
         cnt_in = cnt_ff - 3'd1;
      end
      if (cmd.push_byte || cmd.push_qmark) begin
         emitted_in   = emitted_ff + 16'd1;
         rsp_valid_in = 1'b1;
         rsp_byte_in  = cmd.push_qmark ? QMARK : buf_ff[0];
         rsp_end_in   = 1'b0;
      end
      if (cmd.set_cap) begin
         capped_in = 1'b1;
         cnt_in    = 3'd0;
      end
      if (cmd.push_end) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = 8'h00;
         rsp_end_in   = 1'b1;
         emitted_in   = 16'd0;
         capped_in    = 1'b0;
         cnt_in       = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= 3'd0;
         last_ff      <= 1'b0;
         emitted_ff   <= 16'd0;
         capped_ff    <= 1'b0;
         max_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         last_ff      <= last_in;
         emitted_ff   <= emitted_in;
         capped_ff    <= capped_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff      <= buf_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_end_ff  <= rsp_end_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_is_end   = rsp_end_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'd4) else $error("staging count out of range");
   a_capped_empty: assert property (@(posedge clock) disable iff (reset)
      capped_ff |-> cnt_ff == 3'd0) else $error("bytes held after cap");
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.push_byte || cmd.push_qmark || cmd.push_end) |->
         (out_free && $onehot({cmd.push_byte, cmd.push_qmark, cmd.push_end})))
      else $error("result pushed into a busy slot");

endmodule

[src/u8st_ctrl.sv]
// ----------------------------------------------------------------------------
// u8st_ctrl
// controller: walks the staging buffer one sequence at a time and sequences
// result bytes into the output slot
// ----------------------------------------------------------------------------
module u8st_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  u8st_pkg::dp_status_type status,
   output u8st_pkg::dp_cmd_type    cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EVAL = 2'd1;
   localparam logic [1:0] S_EMIT = 2'd2;
   localparam logic [1:0] S_END  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [1:0] rem_ff, rem_in;

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            priority if (status.cnt_zero || status.wait_more) begin
               state_in = status.last ? S_END : S_IDLE;
            end else if (status.ctrl) begin
               cmd.shift = 1'b1;
            end else if (status.over_cap) begin
               cmd.set_cap = 1'b1;
               state_in    = status.last ? S_END : S_IDLE;
            end else if (status.out_free) begin
               if (status.bad) begin
                  cmd.push_qmark = 1'b1;
               end else begin
                  cmd.push_byte = 1'b1;
                  if (status.len > 3'd1) begin
                     rem_in   = 2'(status.len - 3'd1);
                     state_in = S_EMIT;
                  end
               end
            end
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.push_byte = 1'b1;
               rem_in        = rem_ff - 2'd1;
               if (rem_ff == 2'd1) state_in = S_EVAL;
            end
         end
         S_END: begin
            if (status.out_free) begin
               cmd.push_end = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rem_ff   <= 2'd0;
      end else begin
         state_ff <= state_in;
         rem_ff   <= rem_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;

   a_emit_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT |-> rem_ff != 2'd0) else $error("emit with nothing left");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> state_ff == S_IDLE) else $error("load outside idle");
   a_end_back: assert property (@(posedge clock) disable iff (reset)
      cmd.push_end |=> state_ff == S_IDLE) else $error("end result not followed by idle");

endmodule

[src/utf8_sanitize_truncate.sv]
// ----------------------------------------------------------------------------
// utf8_sanitize_truncate
// streaming utf-8 sanitizer with a per-string output byte cap
// ----------------------------------------------------------------------------
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  req     | req_valid req_ready req_has_byte req_data_byte | in
//          | req_last                                       |
//  rsp     | rsp_valid rsp_ready rsp_out_byte rsp_is_end    | out
//  csr     | csr_valid csr_ready csr_max_out_bytes          | in
//
//  a request is accepted and then the head of the buffer is decoded; each
//  result byte, each dropped control byte and the end result take a step
//  of their own; the single result register and the one-byte-per-cycle
//  shift of the staging buffer set this pace
//  reset (synchronous) empties the buffer, clears the counters and sets the
//  cap to 255
//  a stalled rsp side holds the controller whenever it has a result to push;
//  the last result can sit in the output register while the next request is accepted
// ----------------------------------------------------------------------------
module utf8_sanitize_truncate (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_has_byte,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_is_end,
   // cap register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_max_out_bytes
);

   u8st_pkg::dp_cmd_type    cmd;
   u8st_pkg::dp_status_type status;

   // cap register writes are always taken
   assign csr_ready = 1'b1;

   // controller: one sequence decision per cycle unless a push waits for the result slot, then byte-by-byte emission
   u8st_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: staging buffer of up to four bytes, decode, counters, result slot
   u8st_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_has_byte      (req_has_byte),
      .req_data_byte     (req_data_byte),
      .req_last          (req_last),
      .csr_valid         (csr_valid),
      .csr_max_out_bytes (csr_max_out_bytes),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_is_end        (rsp_is_end)
   );

   // no request is taken while a previous one is still being walked
   a_ready_quiet: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !(cmd.push_byte || cmd.push_qmark || cmd.shift || cmd.set_cap))
      else $error("request taken while buffer busy");
   a_end_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_end) |-> rsp_out_byte == 8'h00)
      else $error("end result carries data");
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready) else $error("cap write refused");

endmodule
